FILE: rtl/circular_array_indexed_list_macros.svh
// Assertion macros for the circular array indexed list.
// Used by circular_array_indexed_list.sv; expects clk and rst_n in scope.
`ifndef CIRCULAR_ARRAY_INDEXED_LIST_MACROS_SVH
`define CIRCULAR_ARRAY_INDEXED_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAIL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAIL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cail_pkg.sv
// Shared codes and fixed widths for the circular array indexed list.
// No dependencies; used by the top level.
package cail_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int ACTION_WIDTH = 2;
    localparam int STATUS_WIDTH = 2;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_GET    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

FILE: rtl/cail_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No dependencies; read during write to the same address returns the old entry.
module cail_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/circular_array_indexed_list.sv
// Circular array indexed list: top level, request sequencer and shift engine.
// Depends on cail_pkg, cail_ram and circular_array_indexed_list_macros.svh.
//
//  channel   handshake            transfer at edge where      payload
//  request   start / busy         start && !busy              action, position, entry_value
//  result    done (strobe)        done (one cycle, no stall)  read_value, status, element_count
//
// After the transfer each request enters S_CHECK, which answers a bad index or a full
// list itself; get and set go on to S_FETCH, an insert shifts in S_SHIFT when entries
// must move and then writes in S_WRITE, and a remove reads in S_FETCH and then shifts;
// moves, the number of entries shifted, is at most about CAPACITY/2. The single RAM
// port pair sets the pace: one entry is read and one written back per cycle.
// Reset clears front pointer, count and control; the RAM is not cleared.
// busy stays high after the transfer and drops in the cycle the result strobe shows.
// The receiver cannot stall; done is high for exactly one cycle per request.
`include "circular_array_indexed_list_macros.svh"

module circular_array_indexed_list #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cail_pkg::ACTION_WIDTH-1:0]  action,
    input  logic [CW-1:0]                      position,
    input  logic [cail_pkg::VALUE_WIDTH-1:0]   entry_value,
    output logic                               done,
    output logic [cail_pkg::VALUE_WIDTH-1:0]   read_value,
    output logic [cail_pkg::STATUS_WIDTH-1:0]  status,
    output logic [CW-1:0]                      element_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_SHIFT,
        S_WRITE
    } state_t;

    // Physical slot of a logical offset from a base; sum stays below 2*CAPACITY for an offset up to CAPACITY.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
    endfunction

    state_t                               state_reg;
    cail_pkg::action_t                    act_reg;
    logic [CW-1:0]                        pos_reg;
    logic [ENTRY_WIDTH-1:0]               val_reg;
    logic [CW-1:0]                        cnt_reg;
    logic [AW-1:0]                        front_reg;
    logic [AW-1:0]                        src_reg;
    logic [AW-1:0]                        dst_reg;
    logic                                 pend_reg;
    logic                                 up_reg;
    logic [CW-1:0]                        left_reg;
    logic [AW-1:0]                        tgt_reg;
    logic                                 fside_reg;
    logic                                 done_reg;
    logic [cail_pkg::VALUE_WIDTH-1:0]     rdv_reg;
    cail_pkg::status_t                    status_reg;

    // Decode of the latched request, valid in S_CHECK.
    logic [AW-1:0]          sp;
    logic [AW-1:0]          sc;
    logic                   is_insert;
    logic                   range_err;
    logic                   full_err;
    logic                   fside;
    logic [AW-1:0]          src_start;
    logic                   up_start;
    logic [CW-1:0]          moves;
    logic [AW-1:0]          tgt_start;

    // RAM port signals.
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    logic [63:0]            val_ext;
    logic [63:0]            rd_ext;

    assign val_ext = 64'(entry_value);
    assign rd_ext  = 64'(ram_rdata);

    always_comb
    begin
        sp        = wrap_add(front_reg, pos_reg);
        sc        = wrap_add(front_reg, cnt_reg);
        is_insert = (act_reg == cail_pkg::ACT_INSERT);
        range_err = is_insert ? (pos_reg > cnt_reg) : (pos_reg >= cnt_reg);
        full_err  = is_insert && (cnt_reg == CW'(CAPACITY));
        fside     = pos_reg < (cnt_reg >> 1);
        src_start = sp;
        up_start  = 1'b0;
        moves     = '0;
        tgt_start = sp;
        unique case (act_reg)
            cail_pkg::ACT_GET,
            cail_pkg::ACT_SET:
            begin
                moves = '0;
            end
            cail_pkg::ACT_INSERT:
            begin
                if (fside)
                begin
                    // Open the slot by pulling the front half one step toward the front.
                    src_start = front_reg;
                    up_start  = 1'b1;
                    moves     = pos_reg;
                    tgt_start = slot_dec(sp);
                end
                else
                begin
                    // Open the slot by pushing the back half one step toward the back.
                    src_start = slot_dec(sc);
                    up_start  = 1'b0;
                    moves     = cnt_reg - pos_reg;
                    tgt_start = sp;
                end
            end
            cail_pkg::ACT_REMOVE:
            begin
                if (fside)
                begin
                    src_start = slot_dec(sp);
                    up_start  = 1'b0;
                    moves     = pos_reg;
                end
                else
                begin
                    src_start = slot_inc(sp);
                    up_start  = 1'b1;
                    moves     = cnt_reg - pos_reg - CW'(1);
                end
            end
            default:
            begin
                moves = '0;
            end
        endcase
    end

    // RAM access: read the target, stream the shift, write the new entry.
    // During a shift the write of one entry and the read of the next lie two
    // slots apart, and each write lands on a free slot or on a slot whose entry was already read.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = sp;
        ram_we    = 1'b0;
        ram_waddr = tgt_reg;
        ram_wdata = val_reg;
        unique case (state_reg)
            S_CHECK:
            begin
                ram_re    = !range_err && !full_err && !is_insert;
                ram_raddr = sp;
            end
            S_FETCH:
            begin
                ram_we    = (act_reg == cail_pkg::ACT_SET);
                ram_waddr = tgt_reg;
                ram_wdata = val_reg;
            end
            S_SHIFT:
            begin
                ram_re    = (left_reg != '0);
                ram_raddr = src_reg;
                ram_we    = pend_reg;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = tgt_reg;
                ram_wdata = val_reg;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    cail_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= cail_pkg::ACT_GET;
            pos_reg    <= '0;
            val_reg    <= '0;
            cnt_reg    <= '0;
            front_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            pend_reg   <= 1'b0;
            up_reg     <= 1'b0;
            left_reg   <= '0;
            tgt_reg    <= '0;
            fside_reg  <= 1'b0;
            done_reg   <= 1'b0;
            rdv_reg    <= '0;
            status_reg <= cail_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        // Latch the request.
                        act_reg   <= cail_pkg::action_t'(action);
                        pos_reg   <= position;
                        val_reg   <= val_ext[ENTRY_WIDTH-1:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    pend_reg  <= 1'b0;
                    fside_reg <= fside;
                    src_reg   <= src_start;
                    up_reg    <= up_start;
                    left_reg  <= moves;
                    tgt_reg   <= tgt_start;
                    rdv_reg   <= '0;
                    priority if (range_err)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= cail_pkg::ST_RANGE;
                        state_reg  <= S_IDLE;
                    end
                    else if (full_err)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= cail_pkg::ST_FULL;
                        state_reg  <= S_IDLE;
                    end
                    else if (is_insert)
                    begin
                        state_reg <= (moves == '0) ? S_WRITE : S_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    rdv_reg <= rd_ext[cail_pkg::VALUE_WIDTH-1:0];
                    if (act_reg == cail_pkg::ACT_REMOVE && left_reg != '0)
                    begin
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        if (act_reg == cail_pkg::ACT_REMOVE)
                        begin
                            cnt_reg <= cnt_reg - CW'(1);
                            if (fside_reg)
                            begin
                                front_reg <= slot_inc(front_reg);
                            end
                        end
                        done_reg   <= 1'b1;
                        status_reg <= cail_pkg::ST_OK;
                        state_reg  <= S_IDLE;
                    end
                end
                S_SHIFT:
                begin
                    if (left_reg != '0)
                    begin
                        // Advance the source; the entry read now lands one step back.
                        src_reg  <= up_reg ? slot_inc(src_reg) : slot_dec(src_reg);
                        dst_reg  <= up_reg ? slot_dec(src_reg) : slot_inc(src_reg);
                        left_reg <= left_reg - CW'(1);
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (act_reg == cail_pkg::ACT_INSERT)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - CW'(1);
                            if (fside_reg)
                            begin
                                front_reg <= slot_inc(front_reg);
                            end
                            done_reg   <= 1'b1;
                            status_reg <= cail_pkg::ST_OK;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                S_WRITE:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (fside_reg)
                    begin
                        front_reg <= slot_dec(front_reg);
                    end
                    rdv_reg    <= '0;
                    done_reg   <= 1'b1;
                    status_reg <= cail_pkg::ST_OK;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign read_value    = rdv_reg;
    assign status        = status_reg;
    assign element_count = cnt_reg;

    // Count never passes the capacity.
    `CAIL_ASSERT_IMP(a_count_bound, 1'b1, cnt_reg <= CW'(CAPACITY), "count above capacity")
    // An accepted request keeps the block busy in the next cycle.
    `CAIL_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request transfer not held busy")
    // A full flag only comes with a full list.
    `CAIL_ASSERT_IMP(a_full_count, done_reg && status_reg == cail_pkg::ST_FULL, cnt_reg == CW'(CAPACITY), "full status with room left")
    // A rejected request leaves count and front untouched.
    `CAIL_ASSERT_NXT(a_range_keeps, state_reg == S_CHECK && range_err, $stable(cnt_reg) && $stable(front_reg), "range error changed state")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for circular_array_indexed_list (16 entries of 32 bits).
// Depends on cail_pkg and the RTL; drives get/set/insert/remove requests and
// checks every result strobe against an in-order list predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH         = 16;
    localparam int POS_W         = 5;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        cail_pkg::action_t act;
        logic [4:0]        pos;
        logic [31:0]       val;
    } list_request_t;

    typedef struct {
        logic [31:0]       read_value;
        cail_pkg::status_t status;
        logic [4:0]        count;
    } list_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        action;
    logic [POS_W-1:0]  position;
    logic [31:0]       entry_value;
    logic              done;
    logic [31:0]       read_value;
    logic [1:0]        status;
    logic [POS_W-1:0]  element_count;

    circular_array_indexed_list #(
        .CAPACITY    (DEPTH),
        .ENTRY_WIDTH (32)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .position      (position),
        .entry_value   (entry_value),
        .done          (done),
        .read_value    (read_value),
        .status        (status),
        .element_count (element_count)
    );

    // Requests waiting to be driven, and results owed by the block, oldest first.
    list_request_t pending_requests[$];
    list_result_t  owed_results[$];

    // Predicted list contents: physical store, front slot and live count.
    logic [31:0] list_mem [DEPTH];
    logic [3:0]  list_front;
    logic [4:0]  list_count;

    // Live count as seen by the stimulus generator, used only to aim positions.
    int          planned_count;

    int          failures;
    int          cycle_count;
    int          gap_left;
    int          burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Map a logical index to its physical slot; the 4-bit cast wraps mod 16.
    function automatic logic [3:0] phys(input int idx);
        return 4'(int'(list_front) + idx);
    endfunction

    // Apply one request to the predicted list and return the result it must give.
    task automatic apply_request(input list_request_t req, output list_result_t res);
        int p;
        int n;
        int j;
        begin
            p = int'(req.pos);
            n = int'(list_count);
            res.read_value = '0;
            res.status     = cail_pkg::ST_OK;
            case (req.act)
                cail_pkg::ACT_GET, cail_pkg::ACT_SET:
                begin
                    if (p >= n)
                        res.status = cail_pkg::ST_RANGE;
                    else
                    begin
                        res.read_value = list_mem[phys(p)];
                        if (req.act == cail_pkg::ACT_SET)
                            list_mem[phys(p)] = req.val;
                    end
                end
                cail_pkg::ACT_INSERT:
                begin
                    if (p > n)
                        res.status = cail_pkg::ST_RANGE;
                    else if (n >= DEPTH)
                        res.status = cail_pkg::ST_FULL;
                    else if (p < n / 2)
                    begin
                        // Open the slot by sliding the front part down one place.
                        list_front = list_front - 4'd1;
                        list_count = list_count + 5'd1;
                        for (j = 0; j < p; j++)
                            list_mem[phys(j)] = list_mem[phys(j + 1)];
                        list_mem[phys(p)] = req.val;
                    end
                    else
                    begin
                        // Open the slot by sliding the back part up one place.
                        list_count = list_count + 5'd1;
                        for (j = n; j > p; j--)
                            list_mem[phys(j)] = list_mem[phys(j - 1)];
                        list_mem[phys(p)] = req.val;
                    end
                end
                default:
                begin
                    if (p >= n)
                        res.status = cail_pkg::ST_RANGE;
                    else
                    begin
                        res.read_value = list_mem[phys(p)];
                        if (p < n / 2)
                        begin
                            // Close the gap from the front and advance the front slot.
                            for (j = p; j > 0; j--)
                                list_mem[phys(j)] = list_mem[phys(j - 1)];
                            list_front = list_front + 4'd1;
                        end
                        else
                        begin
                            for (j = p; j + 1 < n; j++)
                                list_mem[phys(j)] = list_mem[phys(j + 1)];
                        end
                        list_count = list_count - 5'd1;
                    end
                end
            endcase
            res.count = list_count;
        end
    endtask

    // Queue a request and track the count it leaves, so later positions can aim.
    task automatic queue_request(input cail_pkg::action_t act, input int pos,
                                 input logic [31:0] val);
        list_request_t req;
        begin
            req.act = act;
            req.pos = 5'(pos);
            req.val = val;
            pending_requests.push_back(req);
            if (act == cail_pkg::ACT_INSERT && pos <= planned_count && planned_count < DEPTH)
                planned_count++;
            else if (act == cail_pkg::ACT_REMOVE && pos < planned_count)
                planned_count--;
        end
    endtask

    // Gap before the next start: mostly none or short, now and then long,
    // and none at all during a burst.
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (burst_left > 0)
                return 0;
            if (r < 50)
                return 0;
            if (r < 85)
                return $urandom_range(1, 3);
            if (r < 97)
                return $urandom_range(4, 10);
            return $urandom_range(20, 60);
        end
    endfunction

    // Random entry value with the all-zero and all-one words mixed in.
    function automatic logic [31:0] pick_value();
        int r;
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                return 32'h0000_0000;
            if (r == 1)
                return 32'hFFFF_FFFF;
            return $urandom;
        end
    endfunction

    // Driver: hold start with the head request until a transfer, predict the
    // result at that edge, then idle for a random gap before the next one.
    // start gets at most one assignment per edge, so back-to-back stays high.
    always @(posedge clk)
    begin
        list_result_t  res;
        list_request_t req;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !busy)
        begin
            req = pending_requests.pop_front();
            apply_request(req, res);
            owed_results.push_back(res);
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 99) < 2)
                burst_left = $urandom_range(20, 80);
            gap_left = pick_gap();
            if (gap_left == 0 && pending_requests.size() > 0)
            begin
                start       <= 1'b1;
                action      <= pending_requests[0].act;
                position    <= pending_requests[0].pos;
                entry_value <= pending_requests[0].val;
            end
            else
            begin
                start <= 1'b0;
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() > 0)
            begin
                start       <= 1'b1;
                action      <= pending_requests[0].act;
                position    <= pending_requests[0].pos;
                entry_value <= pending_requests[0].val;
            end
        end
    end

    // Monitor: every strobe must match the oldest owed result, field by field.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with nothing owed: read_value %h status %0d count %0d",
                         $time, read_value, status, element_count);
            end
            else
            begin
                want = owed_results.pop_front();
                if (read_value !== want.read_value)
                begin
                    failures++;
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, read_value);
                end
                if (status !== want.status)
                begin
                    failures++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (element_count !== want.count)
                begin
                    failures++;
                    $display("%0t: element_count expected %0d actual %0d",
                             $time, want.count, element_count);
                end
            end
        end
    end

    // Watchdog: a generous cycle budget for the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        int  k;
        int  r;
        int  lim;
        int  pos;
        bit  grow;
        cail_pkg::action_t act;

        rst_n         = 1'b0;
        start         = 1'b0;
        action        = cail_pkg::ACT_GET;
        position      = '0;
        entry_value   = '0;
        failures      = 0;
        cycle_count   = 0;
        gap_left      = 0;
        burst_left    = 0;
        planned_count = 0;
        list_front    = '0;
        list_count    = '0;
        for (k = 0; k < DEPTH; k++)
            list_mem[k] = '0;

        // Directed part: empty-list errors, both insert sides, fill to full,
        // full and bad-index inserts, access at both ends, removes from each side.
        queue_request(cail_pkg::ACT_GET, 0, 32'h0);
        queue_request(cail_pkg::ACT_REMOVE, 0, 32'h0);
        queue_request(cail_pkg::ACT_SET, 0, 32'hDEAD_BEEF);
        queue_request(cail_pkg::ACT_INSERT, 1, 32'h1111_1111);
        queue_request(cail_pkg::ACT_INSERT, 0, 32'hFFFF_FFFF);
        queue_request(cail_pkg::ACT_INSERT, 1, 32'h0000_0000);
        queue_request(cail_pkg::ACT_INSERT, 0, 32'h0000_1234);
        queue_request(cail_pkg::ACT_GET, 2, 32'h0);
        queue_request(cail_pkg::ACT_GET, 31, 32'h0);
        queue_request(cail_pkg::ACT_SET, 1, 32'hA5A5_A5A5);
        // Fill to capacity, alternating front, back and middle inserts so the
        // front slot wraps around the store.
        for (k = 0; planned_count < DEPTH; k++)
            queue_request(cail_pkg::ACT_INSERT, (k % 3 == 0) ? 0 :
                          (k % 3 == 1) ? planned_count : planned_count / 2, $urandom);
        queue_request(cail_pkg::ACT_INSERT, 16, 32'h5555_5555);
        queue_request(cail_pkg::ACT_INSERT, 17, 32'h5555_5555);
        queue_request(cail_pkg::ACT_GET, 15, 32'h0);
        queue_request(cail_pkg::ACT_SET, 15, 32'hFFFF_FFFF);
        queue_request(cail_pkg::ACT_SET, 16, 32'h0);
        queue_request(cail_pkg::ACT_REMOVE, 15, 32'h0);
        queue_request(cail_pkg::ACT_REMOVE, 0, 32'h0);
        queue_request(cail_pkg::ACT_REMOVE, 6, 32'h0);

        // Random part: drift the count up and down between empty and full,
        // with mostly legal positions and a share of out-of-range ones.
        grow = 1'b0;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (planned_count == 0)
                grow = 1'b1;
            else if (planned_count == DEPTH && $urandom_range(0, 99) < 30)
                grow = 1'b0;
            else if ($urandom_range(0, 99) < 3)
                grow = ~grow;

            r = $urandom_range(0, 99);
            if (r < 20)
                act = cail_pkg::ACT_GET;
            else if (r < 40)
                act = cail_pkg::ACT_SET;
            else if (r < 70)
                act = grow ? cail_pkg::ACT_INSERT : cail_pkg::ACT_REMOVE;
            else if (r < 85)
                act = grow ? cail_pkg::ACT_REMOVE : cail_pkg::ACT_INSERT;
            else
                act = (r < 93) ? cail_pkg::ACT_INSERT : cail_pkg::ACT_REMOVE;

            lim = (act == cail_pkg::ACT_INSERT) ? planned_count : planned_count - 1;
            if ($urandom_range(0, 99) < 8 || lim < 0)
                pos = $urandom_range(lim + 1, 31);
            else
                pos = $urandom_range(0, lim);
            queue_request(act, pos, pick_value());
        end

        // Release reset, then let the driver run.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is out and every owed result has come,
        // then allow for any trailing strobe before the verdict.
        while (pending_requests.size() > 0 || owed_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed_results.size() > 0)
        begin
            failures++;
            $display("%0t: %0d results never arrived", $time, owed_results.size());
        end

        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/cail_pkg.sv
rtl/cail_ram.sv
rtl/circular_array_indexed_list.sv
tb/testbench.sv
